@@ hw/rtl/pixel_similarity_graph_defines.svh @@
// assertion helpers for the checker file psg_checker
`ifndef PIXEL_SIMILARITY_GRAPH_DEFINES_SVH
`define PIXEL_SIMILARITY_GRAPH_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define PSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds across reset
`define PSG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/psg_pkg.sv @@
`default_nettype none
package psg_pkg;

  // line store sizing
  localparam int MAX_WIDTH = 1024;
  localparam int WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int ADDR_W    = $clog2(WIDTH_CAP);
  localparam int PADDR_W   = 5;

  typedef logic [ADDR_W-1:0] psg_addr_t;

  // register map
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_LUMA_LIMIT   = 3'd2,
    REG_U_LIMIT      = 3'd3,
    REG_V_LIMIT      = 3'd4
  } psg_reg_t;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd64;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd64;
  localparam logic [8:0]  RST_LUMA_LIMIT   = 9'd48;
  localparam logic [8:0]  RST_U_LIMIT      = 9'd7;
  localparam logic [8:0]  RST_V_LIMIT      = 9'd6;
  localparam logic [10:0] HEIGHT_CAP       = 11'd1024;

  // input actions
  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // mask bits
  localparam int BIT_TOP = 0;
  localparam int BIT_TR  = 1;
  localparam int BIT_R   = 2;
  localparam int BIT_BR  = 3;
  localparam int BIT_B   = 4;
  localparam int BIT_BL  = 5;
  localparam int BIT_L   = 6;
  localparam int BIT_TL  = 7;

  typedef struct packed {
    logic       action;
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } psg_in_t;

  typedef struct packed {
    logic [7:0] neighbour_mask;
    logic [9:0] pixel_row;
    logic [9:0] pixel_column;
    logic       frame_last;
  } psg_out_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } psg_pix_t;

  // 3x3 window, index row*3+column, top-left first
  typedef psg_pix_t [8:0] psg_win_t;

  typedef struct packed {
    logic [8:0] luma;
    logic [8:0] u;
    logic [8:0] v;
  } psg_limits_t;

endpackage
`default_nettype wire

@@ hw/rtl/psg_mask_calc.sv @@
`default_nettype none
module psg_mask_calc (
  input  psg_pkg::psg_win_t    win,
  input  logic [8:0]           win_valid,
  input  psg_pkg::psg_limits_t limits,
  output logic [7:0]           mask
);
  import psg_pkg::*;

  function automatic logic close(input logic [7:0] a, input logic [7:0] b,
                                 input logic [8:0] lim);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {1'b0, d} < lim;
  endfunction

  function automatic logic sim(input psg_win_t w, input logic [8:0] vld,
                               input psg_limits_t l, input int a, input int b);
    return vld[a] && vld[b] &&
           close(w[a].y, w[b].y, l.luma) &&
           close(w[a].u, w[b].u, l.u) &&
           close(w[a].v, w[b].v, l.v);
  endfunction

  logic s41, s42, s45, s48, s47, s46, s43, s40;
  logic s12, s25, s78, s58, s36, s67, s01, s03;

  // edges from the centre
  assign s41 = sim(win, win_valid, limits, 4, 1);
  assign s42 = sim(win, win_valid, limits, 4, 2);
  assign s45 = sim(win, win_valid, limits, 4, 5);
  assign s48 = sim(win, win_valid, limits, 4, 8);
  assign s47 = sim(win, win_valid, limits, 4, 7);
  assign s46 = sim(win, win_valid, limits, 4, 6);
  assign s43 = sim(win, win_valid, limits, 4, 3);
  assign s40 = sim(win, win_valid, limits, 4, 0);

  // outer edges of the four 2x2 blocks
  assign s12 = sim(win, win_valid, limits, 1, 2);
  assign s25 = sim(win, win_valid, limits, 2, 5);
  assign s78 = sim(win, win_valid, limits, 7, 8);
  assign s58 = sim(win, win_valid, limits, 5, 8);
  assign s36 = sim(win, win_valid, limits, 3, 6);
  assign s67 = sim(win, win_valid, limits, 6, 7);
  assign s01 = sim(win, win_valid, limits, 0, 1);
  assign s03 = sim(win, win_valid, limits, 0, 3);

  // a diagonal drops out when its block is fully connected orthogonally
  always_comb begin
    mask         = '0;
    mask[BIT_TOP] = s41;
    mask[BIT_TR]  = s42 && !(s12 && s41 && s25 && s45);
    mask[BIT_R]   = s45;
    mask[BIT_BR]  = s48 && !(s45 && s47 && s78 && s58);
    mask[BIT_B]   = s47;
    mask[BIT_BL]  = s46 && !(s43 && s36 && s47 && s67);
    mask[BIT_L]   = s43;
    mask[BIT_TL]  = s40 && !(s01 && s03 && s41 && s43);
  end

endmodule
`default_nettype wire

@@ hw/rtl/pixel_similarity_graph.sv @@
`default_nettype none
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   psg_in_t: action, luma, chroma_u, chroma_v
// out_     output     out_valid / out_ready psg_out_t: mask, row, column, frame_last
// cfg      apb write  psel & penable & pwrite, pready tied high
//
// one item per cycle unless stalled; results pass stage 1, window and output registers
// one line store read and one write-back per item, forwarded when one address repeats
// reset clears position, window valid flags and pipeline; line store has no clear
// in_ready is low only while a result waits in the output register
module pixel_similarity_graph (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  psg_pkg::psg_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output psg_pkg::psg_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psg_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import psg_pkg::*;

  // configuration registers
  logic [10:0] width_r, height_r;
  logic [8:0]  luma_lim_r, u_lim_r, v_lim_r;
  psg_reg_t    reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = psg_reg_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_IMAGE_WIDTH;
      height_r   <= RST_IMAGE_HEIGHT;
      luma_lim_r <= RST_LUMA_LIMIT;
      u_lim_r    <= RST_U_LIMIT;
      v_lim_r    <= RST_V_LIMIT;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_IMAGE_WIDTH:  width_r    <= pwdata[10:0];
        REG_IMAGE_HEIGHT: height_r   <= pwdata[10:0];
        REG_LUMA_LIMIT:   luma_lim_r <= pwdata[8:0];
        REG_U_LIMIT:      u_lim_r    <= pwdata[8:0];
        REG_V_LIMIT:      v_lim_r    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      REG_IMAGE_WIDTH:  prdata = {21'd0, width_r};
      REG_IMAGE_HEIGHT: prdata = {21'd0, height_r};
      REG_LUMA_LIMIT:   prdata = {23'd0, luma_lim_r};
      REG_U_LIMIT:      prdata = {23'd0, u_lim_r};
      REG_V_LIMIT:      prdata = {23'd0, v_lim_r};
      default:          prdata = '0;
    endcase
  end

  // clamped frame size
  logic [10:0] wc, hc;
  always_comb begin
    priority if (width_r > 11'(WIDTH_CAP)) wc = 11'(WIDTH_CAP);
    else if (width_r == 11'd0)             wc = 11'd1;
    else                                   wc = width_r;
    priority if (height_r > HEIGHT_CAP)    hc = HEIGHT_CAP;
    else if (height_r == 11'd0)            hc = 11'd1;
    else                                   hc = height_r;
  end

  // pipeline advance: everything moves unless a result is stuck
  logic adv, in_acc;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && adv;

  // position of the incoming item and its mask position
  logic [10:0] row_r, row_nxt, ir, er;
  logic [9:0]  col_r, col_nxt, ic, ec;
  logic [10:0] ic_inc;
  logic        have, last, frame_end;
  logic [2:0]  rok, cok;
  logic [8:0]  vld9;
  psg_pix_t    pix;

  always_comb begin
    if ({1'b0, col_r} >= wc) begin
      ic = '0;
      ir = row_r + 11'd1;
    end else begin
      ic = col_r;
      ir = row_r;
    end

    if (ic != 10'd0) begin
      have = ir >= 11'd1;
      er   = ir - 11'd1;
      ec   = ic - 10'd1;
    end else begin
      have = ir >= 11'd2;
      er   = ir - 11'd2;
      ec   = 10'(wc - 11'd1);
    end
    have = have && (er < hc);

    rok  = {({1'b0, er} + 12'd1) < {1'b0, hc}, 1'b1, er != 11'd0};
    cok  = {({1'b0, ec} + 11'd1) < wc, 1'b1, ec != 10'd0};
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        vld9[r*3+c] = have && rok[r] && cok[c];
      end
    end
    last = (er == hc - 11'd1) && ({1'b0, ec} == wc - 11'd1);

    // step the position
    frame_end = {1'b0, ir} >= ({1'b0, hc} + 12'd1);
    ic_inc    = {1'b0, ic} + 11'd1;
    if (frame_end) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (ic_inc >= wc) begin
      row_nxt = ir + 11'd1;
      col_nxt = '0;
    end else begin
      row_nxt = ir;
      col_nxt = ic_inc[9:0];
    end

    pix = (in_data.action == ACT_DRAIN) ? '0 :
          {in_data.luma, in_data.chroma_u, in_data.chroma_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage 1: line store read returns
  logic        s1_v_r;
  psg_addr_t   s1_addr_r, rd_addr;
  psg_pix_t    s1_pix_r;
  logic [8:0]  s1_vld_r;
  logic        s1_have_r, s1_last_r;
  logic [9:0]  s1_er_r, s1_ec_r;

  assign rd_addr = psg_addr_t'(ic);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r <= rd_addr;
      s1_pix_r  <= pix;
      s1_vld_r  <= vld9;
      s1_have_r <= have;
      s1_last_r <= last;
      s1_er_r   <= er[9:0];
      s1_ec_r   <= ec;
    end
  end

  // line store: upper line in the high half, middle line in the low half
  logic [47:0] lb_mem [WIDTH_CAP];
  logic [47:0] rd_r;
  logic        wr_en;
  psg_pix_t    top_eff, mid_eff;

  // forwarding when the item ahead wrote the same column as this read
  logic        fwd_r, fwd_nxt;
  psg_pix_t    fwd_mid_r, fwd_pix_r;

  assign wr_en   = adv && s1_v_r;
  assign fwd_nxt = in_acc && s1_v_r && (rd_addr == s1_addr_r);
  assign top_eff = fwd_r ? fwd_mid_r : psg_pix_t'(rd_r[47:24]);
  assign mid_eff = fwd_r ? fwd_pix_r : psg_pix_t'(rd_r[23:0]);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lb_mem[s1_addr_r] <= {mid_eff, s1_pix_r};
    end
    if (in_acc) begin
      rd_r <= lb_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (adv) begin
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_mid_r <= mid_eff;
      fwd_pix_r <= s1_pix_r;
    end
  end

  // stage 2: window shift
  psg_win_t    win_r;
  logic        s2_v_r, s2_have_r, s2_last_r;
  logic [8:0]  s2_vld_r;
  logic [9:0]  s2_er_r, s2_ec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      s2_vld_r <= '0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2]  <= top_eff;
      win_r[5]  <= mid_eff;
      win_r[8]  <= s1_pix_r;
      s2_have_r <= s1_have_r;
      s2_last_r <= s1_last_r;
      s2_er_r   <= s1_er_r;
      s2_ec_r   <= s1_ec_r;
    end
  end

  // similarity mask
  psg_limits_t limits;
  logic [7:0]  mask;

  assign limits = '{luma: luma_lim_r, u: u_lim_r, v: v_lim_r};

  psg_mask_calc u_mask (
    .win       (win_r),
    .win_valid (s2_vld_r),
    .limits    (limits),
    .mask      (mask)
  );

  // output register
  psg_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r && s2_have_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= '{neighbour_mask: mask, pixel_row: s2_er_r,
                      pixel_column: s2_ec_r, frame_last: s2_last_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ hw/rtl/psg_checker.sv @@
`default_nettype none
`include "pixel_similarity_graph_defines.svh"
module psg_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input psg_pkg::psg_out_t out_data
);
  import psg_pkg::*;

  // a waiting result keeps its value
  `PSG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // input stalls only behind an untaken result
  `PSG_ASSERT(a_in_stall, !in_ready |-> out_valid && !out_ready, "input stalled without output back-pressure")

  // no result straight out of reset
  `PSG_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result shown after reset")

endmodule

bind pixel_similarity_graph psg_checker u_psg_checker (.*);
`default_nettype wire

@@ tb/sv/psg_mask_checker.sv @@
module psg_mask_checker
  import psg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  psg_in_t            in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  psg_out_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 masks_pending,
  output int                 masks_checked,
  output int                 frame_row,
  output int                 frame_col
);

  // window positions, top-left first
  localparam int WP_TL = 0;
  localparam int WP_T  = 1;
  localparam int WP_TR = 2;
  localparam int WP_L  = 3;
  localparam int WP_C  = 4;
  localparam int WP_R  = 5;
  localparam int WP_BL = 6;
  localparam int WP_B  = 7;
  localparam int WP_BR = 8;

  psg_pix_t    upper_line [WIDTH_CAP];
  psg_pix_t    middle_line [WIDTH_CAP];
  psg_pix_t    win [9];
  logic [8:0]  win_in_frame;
  int          pos_row;
  int          pos_col;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [8:0]  luma_lim;
  logic [8:0]  u_lim;
  logic [8:0]  v_lim;
  psg_out_t    masks_due [$];

  function automatic int spread(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // two window pixels are linked when both lie in the frame and every component is close
  function automatic bit alike(int a, int b);
    if (!win_in_frame[a] || !win_in_frame[b]) return 1'b0;
    return spread(win[a].y, win[b].y) < int'(luma_lim) &&
           spread(win[a].u, win[b].u) < int'(u_lim) &&
           spread(win[a].v, win[b].v) < int'(v_lim);
  endfunction

  task automatic report(input string msg);
    if (fail_count < 40) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // advance the window by one item and queue the mask it completes, if any
  task automatic predict_mask(input psg_in_t item);
    int         w, h, ir, ic, er, ec, rr, cc, r, dr, dc;
    psg_pix_t   pix, top_px, mid_px;
    bit         have;
    logic [7:0] mask;
    psg_out_t   due;
    w = width_reg;
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    if (w < 1) w = 1;
    h = height_reg;
    if (h > int'(HEIGHT_CAP)) h = HEIGHT_CAP;
    if (h < 1) h = 1;

    // a column left past the row end by a narrower width wraps first
    ir = pos_row;
    ic = pos_col;
    if (ic >= w) begin
      ic = 0;
      ir++;
    end

    pix = (item.action == ACT_DRAIN) ? '0 : {item.luma, item.chroma_u, item.chroma_v};
    top_px = upper_line[ic];
    mid_px = middle_line[ic];
    upper_line[ic] = mid_px;
    middle_line[ic] = pix;

    for (r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = top_px;
    win[5] = mid_px;
    win[8] = pix;

    // centre pixel sits one row and one column behind the incoming item
    if (ic >= 1) begin
      have = ir >= 1;
      er = ir - 1;
      ec = ic - 1;
    end else begin
      have = ir >= 2;
      er = ir - 2;
      ec = w - 1;
    end
    have = have && er < h;

    win_in_frame = '0;
    if (have) begin
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          rr = er + dr;
          cc = ec + dc;
          if (rr >= 0 && rr < h && cc >= 0 && cc < w) win_in_frame[(dr + 1) * 3 + dc + 1] = 1'b1;
        end
      end
    end

    // the item after the flush row closes the frame
    if (ir >= h + 1) begin
      pos_row = 0;
      pos_col = 0;
    end else begin
      ic++;
      if (ic >= w) begin
        ic = 0;
        ir++;
      end
      pos_row = ir;
      pos_col = ic;
    end

    if (!have) return;

    mask = '0;
    mask[BIT_TOP] = alike(WP_C, WP_T);
    mask[BIT_TR]  = alike(WP_C, WP_TR);
    mask[BIT_R]   = alike(WP_C, WP_R);
    mask[BIT_BR]  = alike(WP_C, WP_BR);
    mask[BIT_B]   = alike(WP_C, WP_B);
    mask[BIT_BL]  = alike(WP_C, WP_BL);
    mask[BIT_L]   = alike(WP_C, WP_L);
    mask[BIT_TL]  = alike(WP_C, WP_TL);

    // a diagonal inside a fully connected 2x2 block is dropped
    if (alike(WP_T, WP_TR) && alike(WP_T, WP_C) && alike(WP_TR, WP_R) && alike(WP_C, WP_R))
      mask[BIT_TR] = 1'b0;
    if (alike(WP_C, WP_R) && alike(WP_C, WP_B) && alike(WP_B, WP_BR) && alike(WP_R, WP_BR))
      mask[BIT_BR] = 1'b0;
    if (alike(WP_L, WP_C) && alike(WP_L, WP_BL) && alike(WP_C, WP_B) && alike(WP_BL, WP_B))
      mask[BIT_BL] = 1'b0;
    if (alike(WP_TL, WP_T) && alike(WP_TL, WP_L) && alike(WP_T, WP_C) && alike(WP_L, WP_C))
      mask[BIT_TL] = 1'b0;

    due.neighbour_mask = mask;
    due.pixel_row      = 10'(er);
    due.pixel_column   = 10'(ec);
    due.frame_last     = (er == h - 1) && (ec == w - 1);
    masks_due.push_back(due);
  endtask

  // compare one accepted result item with the oldest queued mask
  task automatic check_mask(input psg_out_t got);
    psg_out_t want;
    if (masks_due.size() == 0) begin
      report($sformatf("mask for row %0d column %0d with none expected",
                       got.pixel_row, got.pixel_column));
      return;
    end
    want = masks_due.pop_front();
    masks_checked++;
    if (got.neighbour_mask !== want.neighbour_mask)
      report($sformatf("row %0d column %0d: mask %b, expected %b", want.pixel_row,
                       want.pixel_column, got.neighbour_mask, want.neighbour_mask));
    if (got.pixel_row !== want.pixel_row)
      report($sformatf("row %0d expected, got %0d", want.pixel_row, got.pixel_row));
    if (got.pixel_column !== want.pixel_column)
      report($sformatf("row %0d: column %0d expected, got %0d", want.pixel_row,
                       want.pixel_column, got.pixel_column));
    if (got.frame_last !== want.frame_last)
      report($sformatf("row %0d column %0d: frame_last %b, expected %b", want.pixel_row,
                       want.pixel_column, got.frame_last, want.frame_last));
  endtask

  // watch the register port and both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIDTH_CAP; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      win_in_frame = '0;
      pos_row = 0;
      pos_col = 0;
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      luma_lim = RST_LUMA_LIMIT;
      u_lim = RST_U_LIMIT;
      v_lim = RST_V_LIMIT;
      masks_due.delete();
      fail_count = 0;
      masks_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (psg_reg_t'(paddr[PADDR_W-1:2]))
          REG_IMAGE_WIDTH:  width_reg = pwdata[10:0];
          REG_IMAGE_HEIGHT: height_reg = pwdata[10:0];
          REG_LUMA_LIMIT:   luma_lim = pwdata[8:0];
          REG_U_LIMIT:      u_lim = pwdata[8:0];
          REG_V_LIMIT:      v_lim = pwdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_mask(in_data);
      if (out_valid && out_ready) check_mask(out_data);
    end
    masks_pending = masks_due.size();
    frame_row = pos_row;
    frame_col = pos_col;
  end

endmodule

@@ tb/sv/tb_pixel_similarity_graph.sv @@
module tb_pixel_similarity_graph;
  import psg_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_ALWAYS,
    IDLE_SOMETIMES
  } idle_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  psg_in_t            in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  psg_out_t           out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int         fail_count;
  int         masks_pending;
  int         masks_checked;
  int         frame_row;
  int         frame_col;
  idle_mode_t send_mode = IDLE_NONE;
  idle_mode_t recv_mode = IDLE_NONE;
  int         items_sent = 0;
  int         frames_sent = 0;
  int         settings_used = 0;
  int         eff_w = 64;
  int         eff_h = 64;
  psg_pix_t   palette [3];
  int         jitter = 0;

  always #10 clk = ~clk;

  pixel_similarity_graph dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  psg_mask_checker u_mask_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .masks_pending(masks_pending),
    .masks_checked(masks_checked), .frame_row(frame_row), .frame_col(frame_col)
  );

  function automatic int draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_ALWAYS: return $urandom_range(0, 14);
      default:     return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  // offer one item and hold it until accepted; returns on the following falling edge
  task automatic send_item(input psg_in_t item);
    int pause;
    pause = draw_wait(send_mode);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * jitter)) - jitter;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // pixels mostly near a few frame colours so that links form, some fully random
  function automatic psg_in_t make_pixel(logic act);
    psg_in_t  item;
    psg_pix_t p;
    if ($urandom_range(0, 9) == 0) begin
      p = 24'($urandom);
    end else begin
      p = palette[$urandom_range(0, 2)];
      p.y = nudge(p.y);
      p.u = nudge(p.u);
      p.v = nudge(p.v);
    end
    item.action = act;
    item.luma = p.y;
    item.chroma_u = p.u;
    item.chroma_v = p.v;
    return item;
  endfunction

  function automatic logic any_action();
    return ($urandom_range(0, 1) == 0) ? ACT_PUSH : ACT_DRAIN;
  endfunction

  task automatic pick_palette();
    for (int k = 0; k < 3; k++) palette[k] = 24'($urandom);
    jitter = $urandom_range(0, 4);
  endtask

  // one frame of pixels and its flush, optionally broken off part way
  task automatic send_frame(input int w, input int h, input bit cut_short);
    int stop, n;
    stop = cut_short ? $urandom_range(0, w * h + w) : -1;
    pick_palette();
    for (n = 0; n < w * h + w + 1; n++) begin
      if (n == stop) return;
      if (n < w * h)
        send_item(make_pixel(($urandom_range(0, 24) == 0) ? ACT_DRAIN : ACT_PUSH));
      else
        send_item(make_pixel(($urandom_range(0, 11) == 0) ? ACT_PUSH : ACT_DRAIN));
    end
    frames_sent++;
  endtask

  // step through the rest of the current frame with random items
  task automatic realign();
    while (frame_row != 0 || frame_col != 0) send_item(make_pixel(any_action()));
  endtask

  // hold off until every mask is in and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (masks_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // setup phase, access phase, then an idle phase before the next transfer
  task automatic write_reg(input psg_reg_t which, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int w, input int h, input int ly, input int lu, input int lv);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_LUMA_LIMIT, ly);
    write_reg(REG_U_LIMIT, lu);
    write_reg(REG_V_LIMIT, lv);
    eff_w = (w < 1) ? 1 : (w > WIDTH_CAP) ? WIDTH_CAP : w;
    eff_h = (h < 1) ? 1 : (h > int'(HEIGHT_CAP)) ? int'(HEIGHT_CAP) : h;
    settings_used++;
  endtask

  function automatic int pick_limit(int typical);
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 256;
      3: return 255;
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  function automatic int pick_size(int mid_hi);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(9, mid_hi);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // result side: random stalls ahead of each result item
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = draw_wait(recv_mode);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #40_000_000;
    $display("timed out with %0d masks outstanding", masks_pending);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 2x2 frame where every pair links, so the block rule drops both diagonals
    configure(2, 2, 256, 256, 256);
    send_item({ACT_PUSH, 24'h000000});
    send_item({ACT_PUSH, 24'hffffff});
    send_item({ACT_PUSH, 24'hff00ff});
    send_item({ACT_PUSH, 24'h00ff00});
    repeat (3) send_item({ACT_DRAIN, 24'hffffff});

    // single pixel frame with zero limits
    configure(1, 1, 0, 0, 0);
    send_item({ACT_PUSH, 24'hffffff});
    repeat (2) send_item({ACT_DRAIN, 24'h000000});

    // 3x3 frame at reset limits, a drain inside the frame and a push during the flush
    configure(3, 3, RST_LUMA_LIMIT, RST_U_LIMIT, RST_V_LIMIT);
    send_item({ACT_PUSH, 24'h108080});
    send_item({ACT_PUSH, 24'h208281});
    send_item({ACT_PUSH, 24'h908080});
    send_item({ACT_PUSH, 24'h12817f});
    send_item({ACT_DRAIN, 24'h108080});
    send_item({ACT_PUSH, 24'h148380});
    send_item({ACT_PUSH, 24'h308080});
    send_item({ACT_PUSH, 24'h107d82});
    send_item({ACT_PUSH, 24'h118080});
    send_item({ACT_DRAIN, 24'h000000});
    send_item({ACT_PUSH, 24'hff00ff});
    repeat (2) send_item({ACT_DRAIN, 24'h000000});

    // width shrunk while the column is past the new row end
    send_mode = IDLE_ALWAYS;
    recv_mode = IDLE_SOMETIMES;
    configure(6, 5, 48, 7, 6);
    pick_palette();
    repeat (16) send_item(make_pixel(ACT_PUSH));
    settle();
    write_reg(REG_IMAGE_WIDTH, 3);
    realign();

    // height shrunk below the current row, so the next item ends the frame
    repeat (10) send_item(make_pixel(ACT_PUSH));
    settle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    realign();

    // widest row (oversized width clamps), broken off and narrowed mid-frame
    send_mode = IDLE_NONE;
    configure(2047, 2, 256, 16, 16);
    pick_palette();
    repeat (1064) send_item(make_pixel(($urandom_range(0, 24) == 0) ? ACT_DRAIN : ACT_PUSH));
    settle();
    write_reg(REG_IMAGE_WIDTH, 5);
    realign();

    // oversized height on a one pixel column, ended early by a smaller height
    recv_mode = IDLE_NONE;
    configure(1, 2047, 96, 12, 12);
    pick_palette();
    repeat (40) send_item(make_pixel(ACT_PUSH));
    settle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    realign();

    // random settings, mostly whole frames, some broken ones followed by noise
    while (items_sent < 1850) begin
      send_mode = idle_mode_t'($urandom_range(0, 2));
      recv_mode = idle_mode_t'($urandom_range(0, 2));
      configure(pick_size(40), pick_size(20), pick_limit(96), pick_limit(16), pick_limit(16));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 6) == 0) begin
          send_frame(eff_w, eff_h, 1'b1);
          repeat ($urandom_range(0, 5)) send_item(make_pixel(any_action()));
          realign();
        end else begin
          send_frame(eff_w, eff_h, 1'b0);
        end
        if ($urandom_range(0, 9) == 0) settle();
      end
    end

    settle();
    $display("%0d items sent, %0d random-content frames, %0d register settings",
             items_sent, frames_sent, settings_used);
    $display("%0d masks checked, rows from one pixel up to the 1024 pixel clamp",
             masks_checked);
    if (fail_count == 0 && masks_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
